/* src/ple_pkg.sv */
// Shared constants, codes and types of the positional list engine.
`default_nettype none
package ple_pkg;

   localparam int CAPACITY   = 16;
   localparam int DATA_WIDTH = 32;
   localparam int IDX_W      = $clog2(CAPACITY);
   localparam int CNT_W      = $clog2(CAPACITY + 1);
   localparam int FUNC_W     = 4;
   localparam int POS_W      = 5;
   localparam int STAT_W     = 2;

   // request packing: func | value | position, padded to whole bytes
   localparam int REQ_FIELD_W = FUNC_W + DATA_WIDTH + POS_W;
   localparam int REQ_TDATA_W = ((REQ_FIELD_W + 7) / 8) * 8;
   // response packing: status | read_value | found_index | element_count
   localparam int RSP_FIELD_W = STAT_W + DATA_WIDTH + IDX_W + CNT_W;
   localparam int RSP_TDATA_W = ((RSP_FIELD_W + 7) / 8) * 8;

   localparam int RSP_STAT_LO  = 0;
   localparam int RSP_READ_LO  = RSP_STAT_LO + STAT_W;
   localparam int RSP_FOUND_LO = RSP_READ_LO + DATA_WIDTH;
   localparam int RSP_COUNT_LO = RSP_FOUND_LO + IDX_W;

   typedef enum logic [FUNC_W-1:0] {
      FN_INS_FIRST = 4'd0,
      FN_INS_LAST  = 4'd1,
      FN_INS_AT    = 4'd2,
      FN_DEL_FIRST = 4'd3,
      FN_DEL_LAST  = 4'd4,
      FN_DEL_AT    = 4'd5,
      FN_READ      = 4'd6,
      FN_FIND      = 4'd7,
      FN_CLEAR     = 4'd8
   } func_type;

   typedef enum logic [STAT_W-1:0] {
      ST_OK      = 2'd0,
      ST_FULL    = 2'd1,
      ST_RANGE   = 2'd2,
      ST_MISSING = 2'd3
   } status_type;

   // broadcast to every cell of the chain
   typedef struct packed {
      logic                  ins;
      logic                  del;
      logic [CNT_W-1:0]      at;
      logic [DATA_WIDTH-1:0] value;
   } cell_cmd_type;

endpackage
`default_nettype wire

/* src/ple_cell.sv */
// One storage cell of the list chain: holds one element, shifts with its neighbors.
`default_nettype none
module ple_cell #(
   parameter int INDEX = 0
) (
   input  wire logic                           clock,
   input  wire ple_pkg::cell_cmd_type          cmd,
   input  wire logic [ple_pkg::DATA_WIDTH-1:0] left_data,
   input  wire logic [ple_pkg::DATA_WIDTH-1:0] right_data,
   output logic      [ple_pkg::DATA_WIDTH-1:0] data,
   output logic                                match
);

   localparam logic [ple_pkg::CNT_W-1:0] MY_IDX = ple_pkg::CNT_W'(INDEX);

   logic [ple_pkg::DATA_WIDTH-1:0] data_ff;
   logic [ple_pkg::DATA_WIDTH-1:0] data_in;

   always_comb begin
      data_in = data_ff;
      if (cmd.ins) begin
         if (MY_IDX == cmd.at) begin
            data_in = cmd.value;
         end else if (MY_IDX > cmd.at) begin
            data_in = left_data;   // take the element from the lower neighbor
         end
      end else if (cmd.del) begin
         if (MY_IDX >= cmd.at) begin
            data_in = right_data;  // close the gap from the upper neighbor
         end
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data  = data_ff;
   assign match = (data_ff == cmd.value);

endmodule
`default_nettype wire

/* src/positional_list_engine_unit.sv */
// Top level of the positional list engine: request decode, cell chain and response register.
// Usage:
//   An ordered list of up to 16 signed 32-bit elements kept in a chain of
//   cells. Each request transfer on the req_ channel names an operation
//   (insert front/back/at, delete front/back/at, read, find, clear) and
//   produces exactly one response transfer on the rsp_ channel with status,
//   value read, index found and the new element count.
//   A request transfer updates every cell at once (shift up for an insert,
//   shift down for a delete) and latches the per-cell compare flags; the
//   second step priority-encodes the flags and selects the read element into
//   the output register that drives rsp_tvalid.
//   No new request is taken until that two-step pass through the chain is
//   done: req_tready drops for the cycle after each transfer.
//   A new request is taken while the previous response is being transferred,
//   so no extra bubble appears while the receiver keeps rsp_tready high.
//   Stall: while rsp_tvalid is high and rsp_tready low, the response holds
//   and req_tready stays low, so no request is lost.
//   Reset: the synchronous reset empties the list and drops any pending
//   response; cell contents are left as they are and never read before
//   being written again.
`default_nettype none
module positional_list_engine_unit (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_tvalid,
   output logic                                 req_tready,
   // func[3:0], value[35:4], position[40:36], zero pad above
   input  wire logic [ple_pkg::REQ_TDATA_W-1:0] req_tdata,
   output logic                                 rsp_tvalid,
   input  wire logic                            rsp_tready,
   // status[1:0], read_value[33:2], found_index[37:34], element_count[42:38],
   // zero pad above
   output logic      [ple_pkg::RSP_TDATA_W-1:0] rsp_tdata
);

   localparam int CAP = ple_pkg::CAPACITY;
   localparam int DW  = ple_pkg::DATA_WIDTH;
   localparam int IW  = ple_pkg::IDX_W;
   localparam int CW  = ple_pkg::CNT_W;
   localparam int PW  = ple_pkg::POS_W;

   // request fields
   logic [ple_pkg::FUNC_W-1:0] req_func;
   logic [DW-1:0]              req_value;
   logic [PW-1:0]              req_position;

   assign req_func     = req_tdata[ple_pkg::FUNC_W-1:0];
   assign req_value    = req_tdata[ple_pkg::FUNC_W +: DW];
   assign req_position = req_tdata[ple_pkg::FUNC_W + DW +: PW];

   logic accept;

   // list length and two-step control
   logic [CW-1:0] len_ff, len_in;
   logic          busy_ff, busy_in;

   // values latched at the transfer for the second step
   ple_pkg::status_type stat_ff, stat_in;
   logic                is_read_ff, is_read_in;
   logic                is_find_ff, is_find_in;
   logic [IW-1:0]       rd_idx_ff, rd_idx_in;
   logic [CAP-1:0]      match_ff, match_in;

   // response register
   logic                  rsp_valid_ff, rsp_valid_in;
   ple_pkg::status_type   rsp_stat_ff, rsp_stat_in;
   logic [DW-1:0]         rsp_read_ff, rsp_read_in;
   logic [IW-1:0]         rsp_found_ff, rsp_found_in;
   logic [CW-1:0]         rsp_count_ff, rsp_count_in;

   // cell chain
   ple_pkg::cell_cmd_type cmd;
   logic [DW-1:0]         cell_data [CAP];
   logic [CAP-1:0]        cell_match;
   logic                  do_ins, do_del;
   logic [CW-1:0]         at_pos;
   logic                  full;
   logic [CW-1:0]         pos_ext;

   // take a request only when the chain is idle and the output slot frees up
   assign req_tready = !busy_ff && (!rsp_valid_ff || rsp_tready);
   assign accept     = req_tvalid && req_tready;

   assign full    = (len_ff == CW'(CAP));
   assign pos_ext = CW'(req_position);

   // decode against the current length
   always_comb begin
      stat_in    = ple_pkg::ST_OK;
      len_in     = len_ff;
      do_ins     = 1'b0;
      do_del     = 1'b0;
      at_pos     = '0;
      is_read_in = 1'b0;
      is_find_in = 1'b0;
      case (req_func)
         ple_pkg::FN_INS_FIRST, ple_pkg::FN_INS_LAST, ple_pkg::FN_INS_AT: begin
            // fullness wins over a bad position
            if (full) begin
               stat_in = ple_pkg::ST_FULL;
            end else if (req_func == ple_pkg::FN_INS_AT && pos_ext > len_ff) begin
               stat_in = ple_pkg::ST_RANGE;
            end else begin
               do_ins = 1'b1;
               len_in = len_ff + CW'(1);
               if (req_func == ple_pkg::FN_INS_LAST) begin
                  at_pos = len_ff;
               end else if (req_func == ple_pkg::FN_INS_AT) begin
                  at_pos = pos_ext;
               end
            end
         end
         ple_pkg::FN_DEL_FIRST, ple_pkg::FN_DEL_LAST: begin
            if (len_ff == '0) begin
               stat_in = ple_pkg::ST_RANGE;
            end else begin
               do_del = 1'b1;
               len_in = len_ff - CW'(1);
               if (req_func == ple_pkg::FN_DEL_LAST) begin
                  at_pos = len_ff - CW'(1);
               end
            end
         end
         ple_pkg::FN_DEL_AT: begin
            if (pos_ext >= len_ff) begin
               stat_in = ple_pkg::ST_RANGE;
            end else begin
               do_del = 1'b1;
               len_in = len_ff - CW'(1);
               at_pos = pos_ext;
            end
         end
         ple_pkg::FN_READ: begin
            if (pos_ext >= len_ff) begin
               stat_in = ple_pkg::ST_RANGE;
            end else begin
               is_read_in = 1'b1;
            end
         end
         ple_pkg::FN_FIND: begin
            is_find_in = 1'b1;
         end
         ple_pkg::FN_CLEAR: begin
            len_in = '0;
         end
         default: begin
            // unused codes: no change, status ok
         end
      endcase
   end

   assign rd_idx_in = req_position[IW-1:0];

   // broadcast to the chain; cells move only on a transfer
   assign cmd.ins   = accept && do_ins;
   assign cmd.del   = accept && do_del;
   assign cmd.at    = at_pos;
   assign cmd.value = req_value;

   for (genvar g = 0; g < CAP; g++) begin : g_cell
      logic [DW-1:0] left_data;
      logic [DW-1:0] right_data;
      if (g == 0) begin : g_first
         assign left_data = '0;
      end else begin : g_left
         assign left_data = cell_data[g-1];
      end
      if (g == CAP - 1) begin : g_last
         assign right_data = '0;
      end else begin : g_right
         assign right_data = cell_data[g+1];
      end
      ple_cell #(
         .INDEX(g)
      ) u_cell (
         .clock      (clock),
         .cmd        (cmd),
         .left_data  (left_data),
         .right_data (right_data),
         .data       (cell_data[g]),
         .match      (cell_match[g])
      );
      // only occupied cells may report a hit
      assign match_in[g] = cell_match[g] && (CW'(g) < len_ff);
   end

   assign busy_in = accept;

   // second step: encode the first hit, select the read element
   logic [IW-1:0] first_hit;
   always_comb begin
      first_hit = '0;
      for (int i = CAP - 1; i >= 0; i--) begin
         if (match_ff[i]) begin
            first_hit = IW'(i);
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_stat_in  = rsp_stat_ff;
      rsp_read_in  = rsp_read_ff;
      rsp_found_in = rsp_found_ff;
      rsp_count_in = rsp_count_ff;
      if (busy_ff) begin
         rsp_valid_in = 1'b1;
         rsp_stat_in  = stat_ff;
         rsp_read_in  = '0;
         rsp_found_in = '0;
         rsp_count_in = len_ff;
         if (is_read_ff) begin
            rsp_read_in = cell_data[rd_idx_ff];
         end
         if (is_find_ff) begin
            if (|match_ff) begin
               rsp_stat_in  = ple_pkg::ST_OK;
               rsp_found_in = first_hit;
            end else begin
               rsp_stat_in  = ple_pkg::ST_MISSING;
            end
         end
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;  // drop after the transfer
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff       <= '0;
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            len_ff <= len_in;
         end
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      if (accept) begin
         stat_ff    <= stat_in;
         is_read_ff <= is_read_in;
         is_find_ff <= is_find_in;
         rd_idx_ff  <= rd_idx_in;
         match_ff   <= match_in;
      end
      rsp_stat_ff  <= rsp_stat_in;
      rsp_read_ff  <= rsp_read_in;
      rsp_found_ff <= rsp_found_in;
      rsp_count_ff <= rsp_count_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = ple_pkg::RSP_TDATA_W'({rsp_count_ff, rsp_found_ff, rsp_read_ff,
                                              rsp_stat_ff});

endmodule
`default_nettype wire

/* src/ple_checker.sv */
// Port-level checks of the positional list engine, bound to its top level.
`default_nettype none
module ple_checker (
   input wire logic                            clock,
   input wire logic                            reset,
   input wire logic                            req_tvalid,
   input wire logic                            req_tready,
   input wire logic [ple_pkg::REQ_TDATA_W-1:0] req_tdata,
   input wire logic                            rsp_tvalid,
   input wire logic                            rsp_tready,
   input wire logic [ple_pkg::RSP_TDATA_W-1:0] rsp_tdata
);

   localparam int SL = ple_pkg::RSP_STAT_LO;
   localparam int RL = ple_pkg::RSP_READ_LO;
   localparam int FL = ple_pkg::RSP_FOUND_LO;
   localparam int CL = ple_pkg::RSP_COUNT_LO;

   logic                           req_xfer;
   logic [ple_pkg::STAT_W-1:0]     rsp_stat;
   logic [ple_pkg::DATA_WIDTH-1:0] rsp_read;
   logic [ple_pkg::IDX_W-1:0]      rsp_found;
   logic [ple_pkg::CNT_W-1:0]      rsp_count;
   logic                           unused_req;

   assign req_xfer   = req_tvalid && req_tready;
   assign rsp_stat   = rsp_tdata[SL +: ple_pkg::STAT_W];
   assign rsp_read   = rsp_tdata[RL +: ple_pkg::DATA_WIDTH];
   assign rsp_found  = rsp_tdata[FL +: ple_pkg::IDX_W];
   assign rsp_count  = rsp_tdata[CL +: ple_pkg::CNT_W];
   assign unused_req = ^req_tdata;

   // stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response changed while stalled");

   // a request transfer is followed by a cycle without one
   a_req_gap: assert property (@(posedge clock) disable iff (reset)
      req_xfer |=> !req_tready)
      else $error("request taken on consecutive cycles");

   // each request transfer is answered with rsp_tvalid after the chain step and the response register
   a_rsp_latency: assert property (@(posedge clock) disable iff (reset)
      req_xfer |-> ##2 rsp_tvalid)
      else $error("response missing after a request");

   // a refused insert reports a full list
   a_full_count: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_stat == ple_pkg::ST_FULL) |->
         (rsp_count == ple_pkg::CNT_W'(ple_pkg::CAPACITY)))
      else $error("full status with a count below capacity");

   // any failing status carries zero read value and zero index
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_stat != ple_pkg::ST_OK) |->
         (rsp_read == '0) && (rsp_found == '0) && (unused_req || !unused_req))
      else $error("failing response carries data");

endmodule

bind positional_list_engine_unit ple_checker u_ple_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
`default_nettype wire

/* tb/list_engine_checker.sv */
// Checker for the positional list engine: predicts every response and compares it.
module list_engine_checker
   import ple_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_tvalid,
   input  wire logic                   req_tready,
   // func[3:0], value[35:4], position[40:36], zero pad above
   input  wire logic [REQ_TDATA_W-1:0] req_tdata,
   input  wire logic                   rsp_tvalid,
   input  wire logic                   rsp_tready,
   // status[1:0], read_value[33:2], found_index[37:34], element_count[42:38]
   input  wire logic [RSP_TDATA_W-1:0] rsp_tdata,
   output int                          fail_count,
   output int                          outstanding
);

   // first member lands in the highest bits, so status comes last
   typedef struct packed {
      logic [CNT_W-1:0]      element_count;
      logic [IDX_W-1:0]      found_index;
      logic [DATA_WIDTH-1:0] read_value;
      status_type            status;
   } list_answer_type;

   logic [DATA_WIDTH-1:0] cells [CAPACITY];
   int unsigned           cell_count;
   list_answer_type       pending_answers [$];

   initial begin
      fail_count  = 0;
      outstanding = 0;
      cell_count  = 0;
   end

   // apply one request to the shadow list and build the answer it gives
   task automatic apply_list_request(input logic [FUNC_W-1:0] code,
                                     input logic [DATA_WIDTH-1:0] val,
                                     input logic [POS_W-1:0] pos,
                                     output list_answer_type ans);
      int unsigned at;
      bit          do_ins;
      bit          do_del;
      ans    = '0;
      at     = 0;
      do_ins = 1'b0;
      do_del = 1'b0;
      case (code)
         FN_INS_FIRST, FN_INS_LAST, FN_INS_AT: begin
            at = (code == FN_INS_FIRST) ? 0 : (code == FN_INS_LAST) ? cell_count : pos;
            // fullness wins over a bad position
            if (cell_count >= CAPACITY) ans.status = ST_FULL;
            else if (at > cell_count) ans.status = ST_RANGE;
            else do_ins = 1'b1;
         end
         FN_DEL_FIRST, FN_DEL_LAST, FN_DEL_AT: begin
            // an empty list wraps at to a huge value and so falls out of range
            at = (code == FN_DEL_FIRST) ? 0 : (code == FN_DEL_LAST) ? cell_count - 1 : pos;
            if (at >= cell_count) ans.status = ST_RANGE;
            else do_del = 1'b1;
         end
         FN_READ: begin
            if (pos >= cell_count) ans.status = ST_RANGE;
            else ans.read_value = cells[pos];
         end
         FN_FIND: begin
            ans.status = ST_MISSING;
            // scan downward so the lowest match is the one that sticks
            for (int i = int'(cell_count) - 1; i >= 0; i--) begin
               if (cells[i] == val) begin
                  ans.status      = ST_OK;
                  ans.found_index = IDX_W'(i);
               end
            end
         end
         FN_CLEAR: cell_count = 0;
         default: ;
      endcase
      if (do_ins) begin
         for (int i = CAPACITY - 1; i > int'(at); i--) cells[i] = cells[i-1];
         cells[at] = val;
         cell_count++;
      end
      if (do_del) begin
         for (int i = int'(at); i < CAPACITY - 1; i++) cells[i] = cells[i+1];
         cell_count--;
      end
      ans.element_count = CNT_W'(cell_count);
   endtask

   task automatic check_field(input string name, input logic [63:0] want,
                              input logic [63:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      list_answer_type want;
      list_answer_type seen;
      if (reset) begin
         cell_count = 0;
         pending_answers.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            seen = list_answer_type'(rsp_tdata[RSP_FIELD_W-1:0]);
            if (pending_answers.size() == 0) begin
               $display("%0t: unexpected response, expected none, got %0h", $time, seen);
               fail_count++;
            end else begin
               want = pending_answers.pop_front();
               check_field("status", want.status, seen.status);
               check_field("read_value", want.read_value, seen.read_value);
               check_field("found_index", want.found_index, seen.found_index);
               check_field("element_count", want.element_count, seen.element_count);
            end
         end
         if (req_tvalid && req_tready) begin
            apply_list_request(req_tdata[FUNC_W-1:0], req_tdata[FUNC_W +: DATA_WIDTH],
                               req_tdata[FUNC_W+DATA_WIDTH +: POS_W], want);
            pending_answers.push_back(want);
         end
      end
      outstanding = pending_answers.size();
   end

endmodule

/* tb/tb_positional_list_engine_unit.sv */
// Testbench top for the positional list engine: stimulus, flow control and verdict.
module tb_positional_list_engine_unit;
   import ple_pkg::*;

   localparam int          RANDOM_ITEMS = 400;
   localparam int          HOLD_CYCLES  = 80;
   localparam int          DRAIN_CYCLES = 10;
   localparam int          CYCLE_LIMIT  = 200000;
   // func codes past clear do nothing; this is the top of that range
   localparam logic [FUNC_W-1:0] FN_SPARE_LAST = 4'd15;

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata  = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;

   int   fail_count;
   int   outstanding;
   int   idle_pct    = 0;
   int   stall_pct   = 0;
   int   cycle_count = 0;
   logic hold_go     = 1'b0;
   logic hold_rsp    = 1'b0;

   // small pool of values so finds hit and duplicates show up in the list
   logic [DATA_WIDTH-1:0] value_pool [8];

   always #2 clock = ~clock;

   positional_list_engine_unit u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   list_engine_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .fail_count  (fail_count),
      .outstanding (outstanding)
   );

   // Receiver: stall at random per the current phase, and hold off entirely
   // while the long hold-off is running.
   always @(negedge clock) begin
      rsp_tready <= !hold_rsp && ($urandom_range(99) >= stall_pct);
   end

   // Long hold-off: block responses for a fixed stretch of cycles so the engine
   // backs up and drops req_tready while the sender keeps offering.
   initial begin
      wait (hold_go);
      @(negedge clock);
      hold_rsp <= 1'b1;
      repeat (HOLD_CYCLES) @(negedge clock);
      hold_rsp <= 1'b0;
   end

   // Watchdog: stop a hung run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   // Offer one request, idling first at random; return at the falling edge
   // after the transfer so the next call can keep tvalid high without a gap.
   task automatic send_req(input logic [FUNC_W-1:0] code, input logic [DATA_WIDTH-1:0] val,
                           input logic [POS_W-1:0] pos);
      while ($urandom_range(99) < idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= REQ_TDATA_W'({pos, val, code});
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
   endtask

   // Drop tvalid and hold until every outstanding response has come back.
   task automatic wait_drained;
      req_tvalid <= 1'b0;
      @(negedge clock);
      while (outstanding != 0) @(negedge clock);
   endtask

   task automatic set_phase(input int idle, input int stall);
      wait_drained();
      idle_pct  = idle;
      stall_pct = stall;
   endtask

   initial begin
      int                    pick;
      bit                    grow;
      logic [FUNC_W-1:0]     code;
      logic [DATA_WIDTH-1:0] val;
      logic [POS_W-1:0]      pos;

      value_pool[0] = 32'h7FFF_FFFF;
      value_pool[1] = 32'h8000_0000;
      value_pool[2] = 32'hFFFF_FFFF;
      value_pool[3] = 32'h0000_0000;
      value_pool[4] = 32'h0000_0001;
      for (int i = 5; i < 8; i++) value_pool[i] = $urandom;

      repeat (6) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: every refusal on an empty list first.
      send_req(FN_DEL_FIRST, '0, '0);
      send_req(FN_DEL_LAST, '0, '0);
      send_req(FN_DEL_AT, '0, '0);
      send_req(FN_READ, '0, '0);
      send_req(FN_FIND, 32'hFFFF_FFFF, '0);
      send_req(FN_INS_AT, 32'h1234_5678, 5'd1);       // past the end of an empty list
      // Build [max, -1, min, 0] with the value extremes.
      send_req(FN_INS_FIRST, 32'h7FFF_FFFF, '0);
      send_req(FN_INS_LAST, 32'h8000_0000, '0);
      send_req(FN_INS_AT, 32'hFFFF_FFFF, 5'd1);
      send_req(FN_INS_AT, 32'h0000_0000, 5'd3);       // position equal to length appends
      send_req(FN_READ, '0, 5'd0);
      send_req(FN_READ, '0, 5'd3);
      send_req(FN_READ, '0, 5'd4);                    // first index out of range
      send_req(FN_READ, '0, 5'd31);
      send_req(FN_FIND, 32'hFFFF_FFFF, 5'd31);
      send_req(FN_FIND, 32'h0000_0005, '0);           // no match
      send_req(FN_DEL_AT, '0, 5'd1);
      send_req(FN_DEL_AT, '0, 5'd31);
      send_req(FN_SPARE_LAST, 32'hFFFF_FFFF, 5'd31);  // unused code, no effect
      send_req(FN_DEL_FIRST, '0, '0);
      send_req(FN_DEL_LAST, '0, '0);
      send_req(FN_INS_LAST, 32'h5A5A_A5A5, '0);
      send_req(FN_CLEAR, '0, '0);
      send_req(FN_FIND, 32'h5A5A_A5A5, '0);           // not found after clear

      // Random: alternate grow and shrink stretches so the list runs up to full
      // and back down to empty, inside each flow-control phase.
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         case (n)
            0:   set_phase(0, 0);
            100: set_phase(70, 0);
            200: set_phase(0, 70);
            300: set_phase(22, 22);
            default: ;
         endcase
         // start the long hold-off while the sender runs flat out
         if (n == 50) hold_go = 1'b1;
         // one more full pause mid-phase
         if (n == 250) wait_drained();

         grow = ((n / 40) % 2) == 0;
         pick = $urandom_range(99);
         val  = $urandom_range(1) ? value_pool[$urandom_range(7)] : $urandom;
         pos  = ($urandom_range(9) == 0) ? POS_W'($urandom_range(31))
                                         : POS_W'($urandom_range(CAPACITY));
         if (pick < (grow ? 60 : 20))
            code = FUNC_W'($urandom_range(FN_INS_FIRST, FN_INS_AT));
         else if (pick < (grow ? 75 : 65))
            code = FUNC_W'($urandom_range(FN_DEL_FIRST, FN_DEL_AT));
         else if (pick < 82)
            code = FN_READ;
         else if (pick < 94)
            code = FN_FIND;
         else if (pick < 97)
            code = FN_CLEAR;
         else
            code = FUNC_W'($urandom_range(FN_CLEAR + 1, FN_SPARE_LAST));
         if ($urandom_range(19) == 0) value_pool[$urandom_range(7)] = $urandom;
         send_req(code, val, pos);
      end

      // Drain, let the pipeline settle, then give the verdict.
      wait_drained();
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (fail_count == 0 && outstanding == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule
